/* design/arb_pkg.sv */
package arb_pkg;

  localparam int DEFAULT_DEPTH    = 1024;
  localparam int DEFAULT_CHANNELS = 2;

  localparam int SAMPLE_W = 16;
  localparam int THR_W    = 12;
  localparam int STEP_W   = 17;
  localparam int ONE_Q16  = 65536;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_THRESHOLD  = 3'd0,
    REG_HIGH_THRESHOLD = 3'd1,
    REG_NOMINAL_STEP   = 3'd2,
    REG_SLOW_STEP      = 3'd3,
    REG_FAST_STEP      = 3'd4
  } cfg_reg_t;

  localparam logic [THR_W-1:0]  LOW_THRESHOLD_RST  = 12'd128;
  localparam logic [THR_W-1:0]  HIGH_THRESHOLD_RST = 12'd256;
  localparam logic [STEP_W-1:0] NOMINAL_STEP_RST   = 17'd65536;
  localparam logic [STEP_W-1:0] SLOW_STEP_RST      = 17'd64881;
  localparam logic [STEP_W-1:0] FAST_STEP_RST      = 17'd66191;

  // shared multiplier operand widths
  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 20;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // weight divider: scaled numerator divided by six
  localparam int DIV_W = 34;
  // ceil(2^37 / 6), split at bit 18 into a high and a low half
  localparam int RECIP_SHIFT = 37;
  localparam int RECIP_LO_W  = 18;
  localparam logic [RECIP_LO_W-1:0] RECIP_HI = 18'd87381;
  localparam logic [RECIP_LO_W-1:0] RECIP_LO = 18'd87382;

  typedef struct packed {
    logic                       func;
    logic signed [SAMPLE_W-1:0] sample_left;
    logic signed [SAMPLE_W-1:0] sample_right;
    logic                       block_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
  } out_item_t;

endpackage

/* design/adaptive_resampling_ring_buffer.sv */
// Two-channel elastic audio buffer with cubic Lagrange read-out. A write
// transfer (func 0) stores one frame at the write pointer and the block is
// ready again at once. A read transfer (func 1) returns one interpolated
// frame, and the next transfer can be taken once that frame is in the
// output register: all weight and tap arithmetic runs through one 36x20
// signed multiplier under a small sequencer, with a small divide-by-six
// unit that multiplies by a scaled reciprocal. A first step sets up the
// neighbour addresses; each of the four Lagrange weights costs two
// multiplies, a divider start and the divide itself; the four taps then
// cost one buffer read and one multiply per channel each; a last step
// rounds, saturates and steps the position. A result still waiting in the
// output register holds that last step until it is taken.
// The read position steps by the slow, nominal or fast step, picked from the
// read-to-write distance against the two thresholds. Until the first write,
// a read with block_end set puts the position back where its read block
// began. Writes are still taken while a frame waits in the output register.
// No clearing pass is needed after reset: a fill count marks the written rows.
// Configuration writes are taken every cycle and belong in idle periods.
module adaptive_resampling_ring_buffer #(
  parameter int DEPTH    = arb_pkg::DEFAULT_DEPTH,
  parameter int CHANNELS = arb_pkg::DEFAULT_CHANNELS
) (
  input  logic                            clk,
  input  logic                            rst,
  // item channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  arb_pkg::in_item_t               in_item,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output arb_pkg::out_item_t              out_item,
  // register write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [arb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [arb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import arb_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int WPW   = $clog2(DEPTH + 1);
  localparam int PW    = AW + 17;                 // q16 read position
  localparam int CW    = (PW > 28) ? PW : 28;     // distance compare width
  localparam int ROW_W = CHANNELS * SAMPLE_W;
  localparam int ACC_W = 52;
  localparam int EXT   = MUL_A_W - MUL_B_W;

  localparam logic [PW-1:0] SPAN      = PW'(DEPTH * ONE_Q16);
  localparam logic [PW-1:0] POS_RESET = PW'((DEPTH / 2) * ONE_Q16);
  localparam logic [MUL_P_W-1:0] DIV_BIAS = MUL_P_W'(3) << 18;
  localparam logic signed [MUL_B_W-1:0] S_ONE = MUL_B_W'(ONE_Q16);
  localparam logic signed [MUL_B_W-1:0] S_TWO = MUL_B_W'(2 * ONE_Q16);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_WMUL1, S_WMUL2, S_WDIVST, S_WDIV,
    S_RD, S_SMUL0, S_SMUL1, S_SACC, S_FINISH
  } state_t;

  state_t state;

  // registers
  logic [THR_W-1:0]  low_threshold;
  logic [THR_W-1:0]  high_threshold;
  logic [STEP_W-1:0] nominal_step;
  logic [STEP_W-1:0] slow_step;
  logic [STEP_W-1:0] fast_step;

  // buffer state
  logic [WPW-1:0] wp;
  logic [PW-1:0]  pos;
  logic [PW-1:0]  block_start;
  logic           written_yet;
  logic           in_read_block;
  logic           blk_end;

  // sequencer working registers
  logic [1:0]                       k;
  logic [AW-1:0]                    addr [4];
  logic signed [MUL_A_W-1:0]        weight [4];
  logic                             n_neg;
  logic signed [ACC_W-1:0]          acc0;
  logic signed [ACC_W-1:0]          acc1;

  // shared units
  logic                             mul_en;
  logic signed [MUL_A_W-1:0]        mul_a;
  logic signed [MUL_B_W-1:0]        mul_b;
  logic signed [MUL_P_W-1:0]        prod;
  logic                             div_start;
  logic [DIV_W-1:0]                 div_in;
  logic                             div_done;
  logic [DIV_W-1:0]                 div_q;
  logic [MUL_P_W-1:0]               n_mag;
  logic [MUL_P_W-1:0]               n_biased;

  // buffer ports
  logic                             st_we;
  logic [AW-1:0]                    st_waddr;
  logic [ROW_W-1:0]                 st_wdata;
  logic [2*SAMPLE_W-1:0]            both_in;
  logic                             st_re;
  logic [ROW_W-1:0]                 st_rdata;
  logic signed [SAMPLE_W-1:0]       smp0;
  logic signed [SAMPLE_W-1:0]       smp1;

  // interpolation factors from the fractional part
  logic [AW-1:0]                    r_idx;
  logic [AW:0]                      r_p1;
  logic [AW:0]                      r_p2;
  logic [15:0]                      alpha;
  logic signed [MUL_B_W-1:0]        fa, fam, fap, f2m, f3a, f3b;
  logic signed [MUL_B_W-1:0]        third;

  // step selection
  logic [CW-1:0]                    w_q16;
  logic [CW-1:0]                    p_q16;
  logic [CW-1:0]                    distance;
  logic [STEP_W-1:0]                step;
  logic [PW-1:0]                    pos_stepped;
  logic                             in_xfer;
  logic                             out_free;

  function automatic logic signed [SAMPLE_W-1:0] round_sat(
    input logic signed [ACC_W-1:0] a
  );
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] v;
    logic signed [SAMPLE_W-1:0] res;
    mag = a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
    v   = (mag + (ACC_W'(1) << 29)) >> 30;
    if (!a[ACC_W-1]) begin
      res = (v > ACC_W'(32767)) ? 16'sh7fff : SAMPLE_W'(v);
    end else begin
      res = (v > ACC_W'(32768)) ? 16'sh8000 : SAMPLE_W'(-v);
    end
    return res;
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // write side: the pointer wraps just before the store
  assign st_we    = in_xfer && !in_item.func;
  assign st_waddr = (wp == WPW'(DEPTH)) ? '0 : wp[AW-1:0];
  assign both_in  = {in_item.sample_right, in_item.sample_left};
  assign st_wdata = both_in[ROW_W-1:0];
  assign st_re    = (state == S_RD);
  assign smp0     = st_rdata[SAMPLE_W-1:0];
  assign smp1     = st_rdata[ROW_W-1 -: SAMPLE_W];

  // position is below the span once wrapped, so the integer part is the index
  assign r_idx = pos[16 +: AW];
  assign r_p1  = {1'b0, r_idx} + (AW+1)'(1);
  assign r_p2  = {1'b0, r_idx} + (AW+1)'(2);
  assign alpha = pos[15:0];

  always_comb begin
    fa  = $signed({{(MUL_B_W-16){1'b0}}, alpha});
    fam = fa - S_ONE;
    fap = fa + S_ONE;
    f2m = S_TWO - fa;
    f3a = (fa - S_TWO) * MUL_B_W'(3);
    f3b = f2m * MUL_B_W'(3);
    case (k)
      2'd0:    third = f2m;
      2'd1:    third = f3a;
      2'd2:    third = f3b;
      default: third = fam;
    endcase
  end

  // operand selection for the shared multiplier
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      S_WMUL1: begin
        mul_en = 1'b1;
        case (k)
          2'd0: begin
            mul_a = {{EXT{fa[MUL_B_W-1]}}, fa};
            mul_b = fam;
          end
          2'd1: begin
            mul_a = {{EXT{fam[MUL_B_W-1]}}, fam};
            mul_b = fap;
          end
          default: begin
            mul_a = {{EXT{fa[MUL_B_W-1]}}, fa};
            mul_b = fap;
          end
        endcase
      end
      S_WMUL2: begin
        mul_en = 1'b1;
        mul_a  = prod[MUL_A_W-1:0];
        mul_b  = third;
      end
      S_SMUL0: begin
        mul_en = 1'b1;
        mul_a  = weight[k];
        mul_b  = {{(MUL_B_W-SAMPLE_W){smp0[SAMPLE_W-1]}}, smp0};
      end
      S_SMUL1: begin
        mul_en = 1'b1;
        mul_a  = weight[k];
        mul_b  = {{(MUL_B_W-SAMPLE_W){smp1[SAMPLE_W-1]}}, smp1};
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // weight numerator over 6 * 2^18, rounded half away from zero
  assign n_mag     = prod[MUL_P_W-1] ? MUL_P_W'(-prod) : MUL_P_W'(prod);
  assign n_biased  = n_mag + DIV_BIAS;
  assign div_in    = n_biased[18 +: DIV_W];
  assign div_start = (state == S_WDIVST);

  // read-to-write distance, in q16, around the ring
  always_comb begin
    w_q16 = CW'({wp, 16'b0});
    p_q16 = CW'(pos);
    if (p_q16 > w_q16) begin
      distance = w_q16 + CW'(SPAN) - p_q16;
    end else begin
      distance = w_q16 - p_q16;
    end
    if (distance < CW'({low_threshold, 16'b0})) begin
      step = slow_step;
    end else if (distance > CW'({high_threshold, 16'b0})) begin
      step = fast_step;
    end else begin
      step = nominal_step;
    end
    pos_stepped = pos + PW'(step);
  end

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      low_threshold  <= LOW_THRESHOLD_RST;
      high_threshold <= HIGH_THRESHOLD_RST;
      nominal_step   <= NOMINAL_STEP_RST;
      slow_step      <= SLOW_STEP_RST;
      fast_step      <= FAST_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOW_THRESHOLD:  low_threshold  <= cfg_data[THR_W-1:0];
        REG_HIGH_THRESHOLD: high_threshold <= cfg_data[THR_W-1:0];
        REG_NOMINAL_STEP:   nominal_step   <= cfg_data[STEP_W-1:0];
        REG_SLOW_STEP:      slow_step      <= cfg_data[STEP_W-1:0];
        REG_FAST_STEP:      fast_step      <= cfg_data[STEP_W-1:0];
        default:            ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      wp            <= '0;
      pos           <= POS_RESET;
      block_start   <= POS_RESET;
      written_yet   <= 1'b0;
      in_read_block <= 1'b0;
      k             <= '0;
    end else begin
      // the finish step sets valid itself when the old result leaves
      if (out_valid && out_ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (!in_item.func) begin
              wp          <= WPW'(st_waddr) + WPW'(1);
              written_yet <= 1'b1;
            end else begin
              blk_end <= in_item.block_end;
              if (!in_read_block) begin
                block_start   <= pos;
                in_read_block <= 1'b1;
              end
              if (pos >= SPAN) begin
                pos <= pos - SPAN;
              end
              state <= S_PREP;
            end
          end
        end
        S_PREP: begin
          // circular neighbours r-1, r, r+1, r+2
          addr[0] <= (r_idx == '0) ? AW'(DEPTH - 1) : r_idx - AW'(1);
          addr[1] <= r_idx;
          addr[2] <= (r_p1 >= (AW+1)'(DEPTH)) ? AW'(r_p1 - (AW+1)'(DEPTH)) : AW'(r_p1);
          addr[3] <= (r_p2 >= (AW+1)'(DEPTH)) ? AW'(r_p2 - (AW+1)'(DEPTH)) : AW'(r_p2);
          acc0    <= '0;
          acc1    <= '0;
          k       <= '0;
          state   <= S_WMUL1;
        end
        S_WMUL1: state <= S_WMUL2;
        S_WMUL2: state <= S_WDIVST;
        S_WDIVST: begin
          n_neg <= prod[MUL_P_W-1];
          state <= S_WDIV;
        end
        S_WDIV: begin
          if (div_done) begin
            weight[k] <= n_neg ? -MUL_A_W'(div_q) : MUL_A_W'(div_q);
            k         <= k + 2'd1;
            state     <= (k == 2'd3) ? S_RD : S_WMUL1;
          end
        end
        S_RD:    state <= S_SMUL0;
        S_SMUL0: state <= S_SMUL1;
        S_SMUL1: begin
          acc0  <= acc0 + prod[ACC_W-1:0];
          state <= S_SACC;
        end
        S_SACC: begin
          acc1  <= acc1 + prod[ACC_W-1:0];
          k     <= k + 2'd1;
          state <= (k == 2'd3) ? S_FINISH : S_RD;
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid          <= 1'b1;
            out_item.out_left  <= round_sat(acc0);
            out_item.out_right <= (CHANNELS > 1) ? round_sat(acc1) : '0;
            // a block that ends before any write goes back to its start
            if (blk_end) begin
              in_read_block <= 1'b0;
              pos <= written_yet ? pos_stepped : block_start;
            end else begin
              pos <= pos_stepped;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  arb_store #(
    .DEPTH (DEPTH),
    .ROW_W (ROW_W)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (addr[k]),
    .rdata (st_rdata)
  );

  arb_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  arb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_in),
    .done     (div_done),
    .quotient (div_q)
  );

  // a new result only ever comes out of the last step of a read
  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FINISH))
    else $error("result raised outside finish step");

  // the wrapped position always lies inside the ring
  a_pos_wrapped: assert property (@(posedge clk) disable iff (rst)
    (state == S_PREP) |-> (pos < SPAN))
    else $error("read position not wrapped");

  // the divider reports only while the sequencer waits on it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_WDIV))
    else $error("divider result while not waiting");

  a_wp_range: assert property (@(posedge clk) disable iff (rst)
    in_xfer && !in_item.func |=> (wp != '0) && (wp <= WPW'(DEPTH)))
    else $error("write pointer out of range");

endmodule

/* design/arb_store.sv */
module arb_store #(
  parameter int DEPTH = arb_pkg::DEFAULT_DEPTH,
  parameter int ROW_W = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [ROW_W-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [ROW_W-1:0]         rdata
);
  import arb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);

  logic [ROW_W-1:0] mem [DEPTH];
  logic [ROW_W-1:0] rd_raw;
  logic             rd_ok;
  // rows below fill have been written; the rest read as zero
  logic [FW-1:0]    fill;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_raw <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill  <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (we && (FW'(waddr) == fill)) begin
        fill <= fill + FW'(1);
      end
      if (re) begin
        rd_ok <= (FW'(raddr) < fill);
      end
    end
  end

  assign rdata = rd_ok ? rd_raw : '0;

endmodule

/* design/arb_mul.sv */
module arb_mul (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [arb_pkg::MUL_A_W-1:0]  a,
  input  logic signed [arb_pkg::MUL_B_W-1:0]  b,
  output logic signed [arb_pkg::MUL_P_W-1:0]  prod
);
  import arb_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= MUL_P_W'(a) * MUL_P_W'(b);
    end
  end

endmodule

/* design/arb_div.sv */
module arb_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [arb_pkg::DIV_W-1:0]   dividend,
  output logic                        done,
  output logic [arb_pkg::DIV_W-1:0]   quotient
);
  import arb_pkg::*;

  localparam int PROD_W = DIV_W + RECIP_LO_W;

  typedef enum logic [1:0] {
    D_IDLE, D_LOW, D_HIGH
  } phase_t;

  phase_t                phase;
  logic [DIV_W-1:0]      x;
  logic [RECIP_LO_W-1:0] factor;
  logic [PROD_W-1:0]     part;
  logic [PROD_W-1:0]     lo_part;
  logic [PROD_W-1:0]     total;

  // divide by six as x * ceil(2^37 / 6) >> 37, one half of the factor per cycle
  always_comb begin
    factor = (phase == D_LOW) ? RECIP_LO : RECIP_HI;
    part   = PROD_W'(x) * PROD_W'(factor);
    total  = part + (lo_part >> RECIP_LO_W);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        D_IDLE: begin
          if (start) begin
            x     <= dividend;
            phase <= D_LOW;
          end
        end
        D_LOW: begin
          lo_part <= part;
          phase   <= D_HIGH;
        end
        D_HIGH: begin
          quotient <= DIV_W'(total >> (RECIP_SHIFT - RECIP_LO_W));
          done     <= 1'b1;
          phase    <= D_IDLE;
        end
        default: phase <= D_IDLE;
      endcase
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import arb_pkg::*;

  localparam int DEPTH     = 1024;
  localparam longint SPAN  = longint'(DEPTH) * ONE_Q16;
  localparam longint W_DIV = 1572864;
  localparam longint CYCLE_LIMIT = 1500000;
  // index outside the register map, must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  adaptive_resampling_ring_buffer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // frames waiting to be sent and frames the buffer should return
  in_item_t pending_frames[$];
  out_item_t expected_frames[$];
  int errors = 0;
  bit quiet = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;
  longint cycles = 0;

  // shadow of the buffer state
  logic [THR_W-1:0] low_thr;
  logic [THR_W-1:0] high_thr;
  logic [STEP_W-1:0] nom_step, slow_step_q, fast_step_q;
  logic signed [SAMPLE_W-1:0] left_store [DEPTH];
  logic signed [SAMPLE_W-1:0] right_store [DEPTH];
  int wr_ptr;
  longint rd_pos, block_origin;
  bit any_write, reading_block;

  function automatic longint round_div(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  // 4-point cubic lagrange with circular neighbours, rounded and saturated
  function automatic logic signed [SAMPLE_W-1:0] lagrange(bit right_ch, int r, longint a);
    longint s, wm, w0, wp, wpp, acc, v;
    int rm, rp, rpp;
    logic signed [SAMPLE_W-1:0] xm, x0, xp, xpp;
    s = ONE_Q16;
    rm = (r == 0) ? DEPTH - 1 : r - 1;
    rp = (r + 1 >= DEPTH) ? r + 1 - DEPTH : r + 1;
    rpp = (r + 2 >= DEPTH) ? r + 2 - DEPTH : r + 2;
    wm = round_div(-a * (a - s) * (a - 2 * s), W_DIV);
    w0 = round_div(3 * (a - s) * (a + s) * (a - 2 * s), W_DIV);
    wp = round_div(-3 * a * (a + s) * (a - 2 * s), W_DIV);
    wpp = round_div(a * (a + s) * (a - s), W_DIV);
    xm = right_ch ? right_store[rm] : left_store[rm];
    x0 = right_ch ? right_store[r] : left_store[r];
    xp = right_ch ? right_store[rp] : left_store[rp];
    xpp = right_ch ? right_store[rpp] : left_store[rpp];
    acc = longint'(xm) * wm + longint'(x0) * w0 + longint'(xp) * wp + longint'(xpp) * wpp;
    if (acc >= 0) v = (acc + (64'sd1 << 29)) >>> 30;
    else v = -((-acc + (64'sd1 << 29)) >>> 30);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[SAMPLE_W-1:0];
  endfunction

  // apply one accepted frame to the shadow state, queue the read result
  task automatic model_frame(input in_item_t it);
    out_item_t res;
    longint w, distance;
    logic [STEP_W-1:0] step;
    int r;
    if (it.func == 1'b0) begin
      if (wr_ptr >= DEPTH) wr_ptr = 0;
      left_store[wr_ptr] = it.sample_left;
      right_store[wr_ptr] = it.sample_right;
      wr_ptr++;
      any_write = 1'b1;
      return;
    end
    if (!reading_block) begin
      block_origin = rd_pos;
      reading_block = 1'b1;
    end
    if (rd_pos >= SPAN) rd_pos -= SPAN;
    r = int'((rd_pos >> 16) % DEPTH);
    res.out_left = lagrange(1'b0, r, rd_pos & 64'hFFFF);
    res.out_right = lagrange(1'b1, r, rd_pos & 64'hFFFF);
    expected_frames.push_back(res);
    w = longint'(wr_ptr) * ONE_Q16;
    distance = (rd_pos > w) ? w + SPAN - rd_pos : w - rd_pos;
    if (distance < longint'(low_thr) * ONE_Q16) step = slow_step_q;
    else if (distance > longint'(high_thr) * ONE_Q16) step = fast_step_q;
    else step = nom_step;
    rd_pos += step;
    if (it.block_end) begin
      if (!any_write) rd_pos = block_origin;
      reading_block = 1'b0;
    end
  endtask

  // register writes land in the shadow copy, masked to width
  always @(posedge clk) begin
    if (rst) begin
      low_thr <= LOW_THRESHOLD_RST;
      high_thr <= HIGH_THRESHOLD_RST;
      nom_step <= NOMINAL_STEP_RST;
      slow_step_q <= SLOW_STEP_RST;
      fast_step_q <= FAST_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOW_THRESHOLD: begin
          low_thr <= cfg_data[THR_W-1:0];
        end
        REG_HIGH_THRESHOLD: begin
          high_thr <= cfg_data[THR_W-1:0];
        end
        REG_NOMINAL_STEP: begin
          nom_step <= cfg_data;
        end
        REG_SLOW_STEP: begin
          slow_step_q <= cfg_data;
        end
        REG_FAST_STEP: begin
          fast_step_q <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // frame driver: valid holds with its payload until the transfer happens
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      foreach (left_store[i]) begin
        left_store[i] = '0;
        right_store[i] = '0;
      end
      wr_ptr = 0;
      rd_pos = longint'(DEPTH / 2) * ONE_Q16;
      block_origin = rd_pos;
      any_write = 1'b0;
      reading_block = 1'b0;
    end else begin
      if (in_valid && in_ready) model_frame(pending_frames.pop_front());
      if (!(in_valid && !in_ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_frames.size() > 0 && !quiet && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(1, 15) - 1;
          in_valid <= 1'b0;
        end else if (pending_frames.size() > 0) begin
          in_valid <= 1'b1;
          in_item <= pending_frames[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with bursts of back-pressure
  always @(posedge clk) begin
    out_item_t exp_res;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_frames.size() == 0) begin
          $error("result transfer with no frame expected");
          errors++;
        end else begin
          exp_res = expected_frames.pop_front();
          if (out_item.out_left !== exp_res.out_left) begin
            $error("out_left expected %0d actual %0d", exp_res.out_left, out_item.out_left);
            errors++;
          end
          if (out_item.out_right !== exp_res.out_right) begin
            $error("out_right expected %0d actual %0d", exp_res.out_right, out_item.out_right);
            errors++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        recv_gap = $urandom_range(1, 15) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
                          input logic [CFG_DATA_W-1:0] nom, input logic [CFG_DATA_W-1:0] slo,
                          input logic [CFG_DATA_W-1:0] fst);
    write_reg(REG_LOW_THRESHOLD, lo);
    write_reg(REG_HIGH_THRESHOLD, hi);
    write_reg(REG_NOMINAL_STEP, nom);
    write_reg(REG_SLOW_STEP, slo);
    write_reg(REG_FAST_STEP, fst);
  endtask

  // hold off until every frame is sent and every result is back
  task automatic drain();
    while (pending_frames.size() > 0 || expected_frames.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic in_item_t frame(bit rd, int l, int r, bit last);
    in_item_t it;
    it.func = rd;
    it.sample_left = SAMPLE_W'(l);
    it.sample_right = SAMPLE_W'(r);
    it.block_end = last;
    return it;
  endfunction

  // mostly write bursts followed by matching read blocks, some noise
  task automatic add_traffic(input int n, input int read_bias);
    int cnt, len;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(0, 9) < 8) begin
        len = $urandom_range(1, 8);
        repeat (len) pending_frames.push_back(frame(1'b0, $urandom, $urandom,
                                                    $urandom_range(0, 1)));
        len = len + $urandom_range(0, read_bias);
        for (int i = 0; i < len; i++)
          pending_frames.push_back(frame(1'b1, $urandom, $urandom,
                                         (i == len - 1) && ($urandom_range(0, 3) != 0)));
        cnt += 2 * len;
      end else begin
        pending_frames.push_back(frame($urandom_range(0, 1), $urandom, $urandom,
                                       $urandom_range(0, 1)));
        cnt++;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reads before any write: block end puts the position back
    pending_frames.push_back(frame(1'b1, 0, 0, 1'b0));
    pending_frames.push_back(frame(1'b1, 0, 0, 1'b1));
    pending_frames.push_back(frame(1'b1, 0, 0, 1'b1));
    // block_end on a write is ignored; extremes and alternating full scale
    pending_frames.push_back(frame(1'b0, 32767, -32768, 1'b1));
    pending_frames.push_back(frame(1'b0, -32768, 32767, 1'b0));
    pending_frames.push_back(frame(1'b0, 32767, -32768, 1'b0));
    pending_frames.push_back(frame(1'b0, -32768, 32767, 1'b0));
    pending_frames.push_back(frame(1'b0, -1, 0, 1'b0));
    // read block with a write inside it, so no restore at its end
    pending_frames.push_back(frame(1'b1, 0, 0, 1'b0));
    pending_frames.push_back(frame(1'b0, 12345, -12345, 1'b0));
    pending_frames.push_back(frame(1'b1, 0, 0, 1'b0));
    pending_frames.push_back(frame(1'b1, 0, 0, 1'b1));
    drain();

    // full scale pairs that overshoot between taps, to force saturation
    for (int i = 0; i < 16; i++)
      pending_frames.push_back(frame(1'b0, (i % 4 == 1 || i % 4 == 2) ? 32767 : -32768,
                                     (i % 4 == 1 || i % 4 == 2) ? -32768 : 32767, 1'b0));
    drain();
    // near two samples per read, run the position round through the wrap
    write_reg(REG_NOMINAL_STEP, 17'd131071);
    write_reg(REG_SLOW_STEP, 17'd131071);
    write_reg(REG_FAST_STEP, 17'd131071);
    repeat (255) pending_frames.push_back(frame(1'b1, 0, 0, 1'b0));
    drain();
    // quarter steps across the full scale samples
    write_reg(REG_NOMINAL_STEP, 17'd16384);
    write_reg(REG_SLOW_STEP, 17'd16384);
    write_reg(REG_FAST_STEP, 17'd16384);
    repeat (59) pending_frames.push_back(frame(1'b1, 0, 0, 1'b0));
    pending_frames.push_back(frame(1'b1, 0, 0, 1'b1));
    drain();

    // thresholds carry masked-off high bits
    set_regs(17'h1F000, 17'h1FFFF, 17'd65536, 17'd64881, 17'd66191);
    add_traffic(70, 3);
    drain();

    set_regs(17'd2048, 17'd2048, CFG_DATA_W'($urandom_range(0, 131071)),
             CFG_DATA_W'($urandom_range(0, 131071)), CFG_DATA_W'($urandom_range(0, 131071)));
    add_traffic(60, 2);
    drain();

    // last stretch: zero steps, unmapped index, no idling on either side
    write_reg(REG_UNMAPPED, 17'h1FFFF);
    set_regs(17'd4095, 17'd0, 17'd0, 17'd0, CFG_DATA_W'($urandom_range(0, 131071)));
    quiet = 1'b1;
    add_traffic(60, 2);
    drain();
    repeat (200) @(posedge clk);

    if (errors == 0 && expected_frames.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
